// ===== rtl/core/trimmed_mean_window_filter_core_defines.svh =====
// Assertion macros for the trimmed-mean window filter core.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef TRIMMED_MEAN_WINDOW_FILTER_CORE_DEFINES_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TMWF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TMWF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tmwf_pkg.sv =====
// Shared types and constants for the trimmed-mean window filter core.
// No dependencies.
`default_nettype none

package tmwf_pkg;

    localparam int AVG_W           = 28;
    localparam int THR_W           = 28;
    localparam int OPC_W           = 2;
    localparam int FRAC_BITS       = 8;
    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 20;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(65536);

    // Opcodes of an input word
    localparam logic [OPC_W-1:0] OPC_NORMAL = 2'd0;
    localparam logic [OPC_W-1:0] OPC_FILL   = 2'd1;
    localparam logic [OPC_W-1:0] OPC_ZREF   = 2'd2;
    localparam logic [OPC_W-1:0] OPC_SHIFT  = 2'd3;

    // What a window cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FILL,
        CELL_STEP
    } cell_op_t;

    // Top-level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_TRIM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tmwf_cell.sv =====
// One window cell: holds a sample, loads the fill value or takes its neighbor's.
// Depends on tmwf_pkg.
`default_nettype none

module tmwf_cell #(
    parameter int WIDTH = tmwf_pkg::SAMPLE_BITS_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  tmwf_pkg::cell_op_t   op,
    input  wire [WIDTH-1:0]      fill_in,
    input  wire [WIDTH-1:0]      nb_in,
    output logic [WIDTH-1:0]     q
);
    import tmwf_pkg::*;

    logic [WIDTH-1:0] val_reg;
    logic [WIDTH-1:0] val_next;

    // load select
    always_comb begin
        unique case (op)
            CELL_FILL: val_next = fill_in;
            CELL_STEP: val_next = nb_in;
            default:   val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else begin
            val_reg <= val_next;
        end
    end

    assign q = val_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tmwf_div.sv =====
// Divider by the constant WINDOW-2: reciprocal multiplication in three registered steps.
// Depends on tmwf_pkg.
`default_nettype none

module tmwf_div #(
    parameter int WINDOW      = tmwf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = tmwf_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                                        aclk,
    input  wire                                                        aresetn,
    input  wire                                                        start,
    input  wire [SAMPLE_BITS+$clog2(WINDOW)+tmwf_pkg::FRAC_BITS-1:0]   num,
    output logic                                                       busy,
    output logic [SAMPLE_BITS+tmwf_pkg::FRAC_BITS-1:0]                 quotient
);
    import tmwf_pkg::*;

    localparam int SW   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int NW   = SW + FRAC_BITS;
    localparam int DIVR = WINDOW - 2;
    localparam int DB   = $clog2(DIVR);
    localparam int RB   = DB + 1;
    localparam int TW   = RB + FRAC_BITS;
    localparam int K1   = SW + DB;
    localparam int K2   = TW + DB;
    localparam int P1W  = 2 * SW + 1;
    localparam int P2W  = 2 * TW + 1;
    // reciprocals rounded up; exact for every operand of the stated width
    localparam longint unsigned M1 = ((64'd1 << K1) + 64'(DIVR - 1)) / 64'(DIVR);
    localparam longint unsigned M2 = ((64'd1 << K2) + 64'(DIVR - 1)) / 64'(DIVR);

    logic [2:0]             stg_reg, stg_next;
    logic [NW-1:0]          num_reg, num_next;
    logic [SAMPLE_BITS-1:0] quo_hi_reg, quo_hi_next;
    logic [RB-1:0]          rem_reg, rem_next;
    logic [FRAC_BITS-1:0]   quo_lo_reg, quo_lo_next;
    logic [SW-1:0]          num_hi;
    logic [P1W-1:0]         prod1;
    logic [SW-1:0]          back_mul;
    logic [SW-1:0]          rem_full;
    logic [TW-1:0]          low_num;
    logic [P2W-1:0]         prod2;

    // high quotient: integer part of the numerator over the divisor
    assign num_hi   = num_reg[NW-1:FRAC_BITS];
    assign prod1    = P1W'(num_hi) * P1W'(M1);

    // remainder of the integer part, below the divisor
    assign back_mul = SW'(quo_hi_reg) * SW'(DIVR);
    assign rem_full = num_hi - back_mul;

    // low quotient: (remainder * 256 + low byte) / divisor, always below 256
    assign low_num  = {rem_reg, num_reg[FRAC_BITS-1:0]};
    assign prod2    = P2W'(low_num) * P2W'(M2);

    // one step per cycle, stage bits travel with the work
    always_comb begin
        stg_next    = {stg_reg[1:0], 1'b0};
        num_next    = num_reg;
        quo_hi_next = quo_hi_reg;
        rem_next    = rem_reg;
        quo_lo_next = quo_lo_reg;
        if (start) begin
            stg_next = 3'b001;
            num_next = num;
        end
        if (stg_reg[0]) begin
            quo_hi_next = prod1[K1 +: SAMPLE_BITS];
        end
        if (stg_reg[1]) begin
            rem_next = rem_full[RB-1:0];
        end
        if (stg_reg[2]) begin
            quo_lo_next = prod2[K2 +: FRAC_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_reg <= '0;
        end else begin
            stg_reg <= stg_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg    <= num_next;
        quo_hi_reg <= quo_hi_next;
        rem_reg    <= rem_next;
        quo_lo_reg <= quo_lo_next;
    end

    assign busy     = |stg_reg;
    assign quotient = {quo_hi_reg, quo_lo_reg};

endmodule

`default_nettype wire

// ===== rtl/core/trimmed_mean_window_filter_core.sv =====
// Trimmed-mean window filter core: window cell chain, sequencer, output register.
// Depends on tmwf_pkg, tmwf_cell, tmwf_div and the core defines header.
//
// Usage:
//   Input words (s_sample, s_opcode) come in on s_valid/s_ready; each gives
//   exactly one result word (m_average, m_held) on m_valid/m_ready.
//   cfg_wr_en/cfg_wr_data write the outlier threshold; write it only while idle.
//   A word is taken only while the sequencer is idle. A rejected outlier
//   goes straight to the output state. Any other word updates the window,
//   then walks it once around the cell chain gathering sum, minimum and
//   maximum, trims the extremes, runs the reciprocal divider, stores the
//   result and loads the output register; only then can the next word be
//   taken. The window walk sets the rate.
//   The output register holds a finished word while the receiver stalls; the
//   core still takes the next word, but that result waits in the output state,
//   with no further word taken, until the register frees.
//   Synchronous active-low reset clears the window, last result and outlier
//   count, and restores the threshold to 256.0.
`default_nettype none
`include "trimmed_mean_window_filter_core_defines.svh"

module trimmed_mean_window_filter_core #(
    parameter int WINDOW      = tmwf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = tmwf_pkg::SAMPLE_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire [tmwf_pkg::THR_W-1:0]    cfg_wr_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [SAMPLE_BITS-1:0]        s_sample,
    input  wire [tmwf_pkg::OPC_W-1:0]    s_opcode,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [tmwf_pkg::AVG_W-1:0]   m_average,
    output logic                         m_held
);
    import tmwf_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(WINDOW);
    localparam int SW    = SB + $clog2(WINDOW);
    localparam int NW    = SW + FRAC_BITS;
    localparam int QW    = SB + FRAC_BITS;
    localparam int CMP_W = ((QW > AVG_W) ? QW : AVG_W) + 1;
    localparam logic [FRAC_BITS-1:0] HALF_DIV = FRAC_BITS'((WINDOW - 2) / 2);

    state_t             state_reg, state_next;
    logic [1:0]         ocnt_reg, ocnt_next;
    logic [AVG_W-1:0]   last_avg_reg, last_avg_next;
    logic [THR_W-1:0]   thr_reg;
    logic               held_reg, held_next;
    logic [AW-1:0]      acc_cnt_reg, acc_cnt_next;
    logic [SW-1:0]      sum_reg, sum_next;
    logic [SB-1:0]      lo_reg, lo_next;
    logic [SB-1:0]      hi_reg, hi_next;
    logic               m_valid_reg, m_valid_next;
    logic [AVG_W-1:0]   m_avg_reg, m_avg_next;
    logic               m_held_reg, m_held_next;

    cell_op_t           cell_op;
    logic [SB-1:0]      last_nb;
    logic [SB-1:0]      q [WINDOW];
    logic               div_start;
    logic               div_busy;
    logic [QW-1:0]      div_quo;
    logic [NW-1:0]      div_num;
    logic [SW-1:0]      trim_sum;

    logic [CMP_W-1:0]   scaled_x, avg_x, thr_x;
    logic               is_outlier;
    logic               held_now;
    logic               held_acc;

    // window cell chain: cell i takes cell i+1, the tail takes last_nb
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        if (i == WINDOW - 1) begin : g_tail
            tmwf_cell #(.WIDTH(SB)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .op      (cell_op),
                .fill_in (s_sample),
                .nb_in   (last_nb),
                .q       (q[i])
            );
        end else begin : g_body
            tmwf_cell #(.WIDTH(SB)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .op      (cell_op),
                .fill_in (s_sample),
                .nb_in   (q[i+1]),
                .q       (q[i])
            );
        end
    end

    // trimmed sum with rounding half appended below the binary point
    assign trim_sum = sum_reg - SW'(lo_reg) - SW'(hi_reg);
    assign div_num  = {trim_sum, HALF_DIV};

    tmwf_div #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // outlier band test on exact integers
    assign scaled_x   = CMP_W'({s_sample, {FRAC_BITS{1'b0}}});
    assign avg_x      = CMP_W'(last_avg_reg);
    assign thr_x      = CMP_W'(thr_reg);
    assign is_outlier = (s_opcode == OPC_NORMAL) &&
                        ((scaled_x > avg_x + thr_x) || (scaled_x + thr_x < avg_x));
    assign held_now   = is_outlier && (ocnt_reg != 2'd3);

    assign s_ready  = (state_reg == ST_IDLE);
    assign held_acc = s_valid && s_ready && held_now;

    // sequencer: next state, cell control and datapath updates
    always_comb begin
        state_next    = state_reg;
        ocnt_next     = ocnt_reg;
        last_avg_next = last_avg_reg;
        held_next     = held_reg;
        acc_cnt_next  = acc_cnt_reg;
        sum_next      = sum_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        m_valid_next  = m_valid_reg;
        m_avg_next    = m_avg_reg;
        m_held_next   = m_held_reg;
        cell_op       = CELL_HOLD;
        last_nb       = s_sample;
        div_start     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (held_now) begin
                        ocnt_next  = ocnt_reg + 2'd1;
                        held_next  = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        held_next    = 1'b0;
                        acc_cnt_next = '0;
                        state_next   = ST_ACC;
                        if (is_outlier || s_opcode == OPC_FILL) begin
                            cell_op   = CELL_FILL;
                            ocnt_next = 2'd0;
                        end else begin
                            cell_op = CELL_STEP;
                            if (s_opcode != OPC_ZREF) begin
                                ocnt_next = 2'd0;
                            end
                        end
                    end
                end
            end
            ST_ACC: begin
                // rotate once around; the head word feeds sum, min and max
                cell_op      = CELL_STEP;
                last_nb      = q[0];
                acc_cnt_next = acc_cnt_reg + AW'(1);
                if (acc_cnt_reg == '0) begin
                    sum_next = SW'(q[0]);
                    lo_next  = q[0];
                    hi_next  = q[0];
                end else begin
                    sum_next = sum_reg + SW'(q[0]);
                    lo_next  = (q[0] < lo_reg) ? q[0] : lo_reg;
                    hi_next  = (q[0] > hi_reg) ? q[0] : hi_reg;
                end
                if (acc_cnt_reg == AW'(WINDOW - 1)) begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    last_avg_next = AVG_W'(div_quo);
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_avg_next   = last_avg_reg;
                    m_held_next  = held_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ocnt_reg     <= 2'd0;
            last_avg_reg <= '0;
            thr_reg      <= THR_RESET;
            acc_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ocnt_reg     <= ocnt_next;
            last_avg_reg <= last_avg_next;
            acc_cnt_reg  <= acc_cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        held_reg   <= held_next;
        sum_reg    <= sum_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        m_avg_reg  <= m_avg_next;
        m_held_reg <= m_held_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_average = m_avg_reg;
    assign m_held    = m_held_reg;

    `TMWF_ASSERT_NEXT(a_held_keeps_avg, held_acc, $stable(last_avg_reg), "held word moved result")
    `TMWF_ASSERT_NEXT(a_held_counts, held_acc, ocnt_reg != 2'd0, "outlier count not advanced")
    `TMWF_ASSERT_NOW(a_div_idle, state_reg == ST_IDLE, !div_busy, "divider busy while idle")
    `TMWF_ASSERT_NEXT(a_trim_starts_div, state_reg == ST_TRIM, div_busy, "divider not started")

endmodule

`default_nettype wire
